// ----- design/stereo_bass_mono_crossover_top_defines.svh -----
// ----------------------------------------------------------------------------
// Crossover assertion macros
// Shared assertion wrappers for the stereo bass-mono crossover checkers.
// ----------------------------------------------------------------------------
`ifndef STEREO_BASS_MONO_CROSSOVER_TOP_DEFINES_SVH
`define STEREO_BASS_MONO_CROSSOVER_TOP_DEFINES_SVH

// checked only while out of reset
`define SBMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define SBMC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- design/sbmc_pkg.sv -----
// ----------------------------------------------------------------------------
// Crossover package
// Widths, register indexes and shared types of the bass-mono crossover.
// ----------------------------------------------------------------------------
`default_nettype none

package sbmc_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 30;
    localparam int STATE_BITS     = 48;
    // accumulator headroom over the state width
    localparam int ACC_BITS       = STATE_BITS + 4;
    // multiplier B side: a sample, the signed upper or unsigned lower state part
    localparam int MUL_B_BITS     = 33;
    localparam int PROD_BITS      = COEF_BITS + MUL_B_BITS;
    localparam int LO_BITS        = 32;
    localparam int HI_SHIFT       = LO_BITS - COEF_FRAC_BITS;

    localparam int CFG_IDX_BITS   = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_B0 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_B1 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_B2 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_A1 = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_A2 = 3'd5;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } coef_t;

    typedef struct packed {
        logic start;
        logic pass;
    } mix_req_t;

    typedef struct packed {
        logic                          done;
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
    } mix_out_t;

endpackage

`default_nettype wire

// ----- design/stereo_bass_mono_crossover_top.sv -----
// ----------------------------------------------------------------------------
// Stereo bass-mono crossover
// Low-passes both channels with one shared biquad setting and folds the bass
// of the pair into mono, leaving the upper band of each channel untouched.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one stereo sample pair per beat. m_ channel: the processed
//   pair. cfg_ channel: register writes (enable, b0, b1, b2, a1, a2), always
//   ready; write only while no beat is in flight.
//   One pair is processed at a time. With enable set, a pair passes from the
//   accepting edge through launch, the nine-step multiply sequence of each
//   lane (one 32x33 multiplier per channel), mix and output register, and
//   s_tready returns in the same cycle as m_tvalid rises, so the next pair
//   is taken only once the last one has reached the output register.
//   With enable clear the pair is copied through launch, mix and output
//   register, and the filter state stays as it was.
//   The result waits in the output register while m_tready is low; the next
//   input pair is still accepted and computed, and holds in the mix stage
//   until the output register frees up.
//   Reset (aresetn low, synchronous) clears the filter state, disables the
//   block, zeroes the coefficients and drops m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_bass_mono_crossover_top (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [2*sbmc_pkg::SAMPLE_BITS-1:0]     s_tdata,  // sample_right upper half, sample_left lower
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [2*sbmc_pkg::SAMPLE_BITS-1:0]          m_tdata,  // out_right in the upper half, out_left in the lower
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [sbmc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [sbmc_pkg::COEF_BITS-1:0]         cfg_data
);

    localparam int SB = sbmc_pkg::SAMPLE_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAUNCH,
        S_RUN,
        S_MIX,
        S_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [2*SB-1:0]       m_tdata_reg, m_tdata_next;
    logic signed [SB-1:0]  x_left_reg, x_right_reg;
    logic                  enable_reg;
    sbmc_pkg::coef_t       coef_reg;

    logic                  in_beat, out_free, lane_start;
    logic                  done_left, done_right;
    logic signed [sbmc_pkg::STATE_BITS-1:0] bass_left, bass_right;
    sbmc_pkg::mix_req_t    mix_req;
    sbmc_pkg::mix_out_t    mix_res;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            coef_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sbmc_pkg::CFG_ENABLE:  enable_reg  <= cfg_data[0];
                sbmc_pkg::CFG_COEF_B0: coef_reg.b0 <= cfg_data;
                sbmc_pkg::CFG_COEF_B1: coef_reg.b1 <= cfg_data;
                sbmc_pkg::CFG_COEF_B2: coef_reg.b2 <= cfg_data;
                sbmc_pkg::CFG_COEF_A1: coef_reg.a1 <= cfg_data;
                sbmc_pkg::CFG_COEF_A2: coef_reg.a2 <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            x_left_reg  <= s_tdata[SB-1:0];
            x_right_reg <= s_tdata[2*SB-1:SB];
        end
    end

    sbmc_biquad_lane u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lane_start),
        .x       (x_left_reg),
        .coef    (coef_reg),
        .done    (done_left),
        .bass    (bass_left)
    );

    sbmc_biquad_lane u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lane_start),
        .x       (x_right_reg),
        .coef    (coef_reg),
        .done    (done_right),
        .bass    (bass_right)
    );

    sbmc_mix u_mix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (mix_req),
        .x_left     (x_left_reg),
        .x_right    (x_right_reg),
        .bass_left  (bass_left),
        .bass_right (bass_right),
        .result     (mix_res)
    );

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        lane_start    = 1'b0;
        mix_req       = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    state_next = S_LAUNCH;
                end
            end
            S_LAUNCH: begin
                if (enable_reg) begin
                    lane_start = 1'b1;
                    state_next = S_RUN;
                end else begin
                    mix_req.start = 1'b1;
                    mix_req.pass  = 1'b1;
                    state_next    = S_MIX;
                end
            end
            S_RUN: begin
                // both lanes run in lockstep
                if (done_left && done_right) begin
                    mix_req.start = 1'b1;
                    state_next    = S_MIX;
                end
            end
            S_MIX, S_OUT: begin
                if (mix_res.done || state_reg == S_OUT) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = {mix_res.out_right, mix_res.out_left};
                        state_next    = S_IDLE;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- design/sbmc_biquad_lane.sv -----
// ----------------------------------------------------------------------------
// Biquad lane
// One channel's transposed direct-form-II low-pass section on a single
// shared 32x33 multiplier, sequenced over nine steps.
// ----------------------------------------------------------------------------
`default_nettype none

module sbmc_biquad_lane (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   start,
    input  wire logic signed [sbmc_pkg::SAMPLE_BITS-1:0] x,
    input  wire sbmc_pkg::coef_t                        coef,
    output logic                                        done,
    output logic signed [sbmc_pkg::STATE_BITS-1:0]      bass
);

    localparam int SB = sbmc_pkg::SAMPLE_BITS;
    localparam int WB = sbmc_pkg::STATE_BITS;
    localparam int AB = sbmc_pkg::ACC_BITS;
    localparam int MB = sbmc_pkg::MUL_B_BITS;
    localparam int PB = sbmc_pkg::PROD_BITS;
    localparam int LB = sbmc_pkg::LO_BITS;
    localparam int HS = sbmc_pkg::HI_SHIFT;
    localparam int FB = sbmc_pkg::COEF_FRAC_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_B0,
        ST_BASS,
        ST_LOAD_B1,
        ST_SUB_A1_HI,
        ST_SUB_A1_LO,
        ST_STORE_W1,
        ST_SUB_A2_HI,
        ST_SUB_A2_LO,
        ST_STORE_W2
    } step_t;

    function automatic logic signed [WB-1:0] sat_state(input logic signed [AB-1:0] v);
        logic [AB-WB:0] top;
        top = v[AB-1:WB-1];
        if ((&top) || !(|top)) begin
            sat_state = v[WB-1:0];
        end else begin
            sat_state = {v[AB-1], {(WB-1){~v[AB-1]}}};
        end
    endfunction

    step_t                       step_reg, step_next;
    logic signed [PB-1:0]        mul_reg, mul_next;
    logic signed [AB-1:0]        acc_reg, acc_next;
    logic signed [WB-1:0]        bass_reg, bass_next;
    logic signed [WB-1:0]        w1_reg, w1_next;
    logic signed [WB-1:0]        w2_reg, w2_next;
    logic signed [sbmc_pkg::COEF_BITS-1:0] mul_a;
    logic signed [MB-1:0]        mul_b;
    logic signed [MB-1:0]        b_x, b_hi, b_lo;
    logic signed [AB-1:0]        prod_term, hi_term, lo_term, w1_ext, w2_ext;
    logic signed [PB-1:0]        lo_shift;

    assign b_x  = {{(MB-SB){x[SB-1]}}, x};
    assign b_hi = {{(MB-(WB-LB)){bass_reg[WB-1]}}, bass_reg[WB-1:LB]};
    assign b_lo = {{(MB-LB){1'b0}}, bass_reg[LB-1:0]};

    // b*x products and the upper partial product both fit the accumulator
    assign prod_term = mul_reg[AB-1:0];
    assign hi_term   = {mul_reg[AB-1-HS:0], {HS{1'b0}}};
    assign lo_shift  = mul_reg >>> FB;
    assign lo_term   = lo_shift[AB-1:0];
    assign w1_ext    = {{(AB-WB){w1_reg[WB-1]}}, w1_reg};
    assign w2_ext    = {{(AB-WB){w2_reg[WB-1]}}, w2_reg};

    assign mul_next = mul_a * mul_b;

    always_comb begin
        step_next = step_reg;
        acc_next  = acc_reg;
        bass_next = bass_reg;
        w1_next   = w1_reg;
        w2_next   = w2_reg;
        mul_a     = '0;
        mul_b     = '0;
        done      = 1'b0;
        unique case (step_reg)
            ST_IDLE: begin
                if (start) begin
                    step_next = ST_MUL_B0;
                end
            end
            ST_MUL_B0: begin
                mul_a     = coef.b0;
                mul_b     = b_x;
                step_next = ST_BASS;
            end
            ST_BASS: begin
                bass_next = sat_state(prod_term + w1_ext);
                mul_a     = coef.b1;
                mul_b     = b_x;
                step_next = ST_LOAD_B1;
            end
            ST_LOAD_B1: begin
                acc_next  = prod_term;
                mul_a     = coef.a1;
                mul_b     = b_hi;
                step_next = ST_SUB_A1_HI;
            end
            ST_SUB_A1_HI: begin
                acc_next  = acc_reg - hi_term;
                mul_a     = coef.a1;
                mul_b     = b_lo;
                step_next = ST_SUB_A1_LO;
            end
            ST_SUB_A1_LO: begin
                acc_next  = acc_reg - lo_term;
                mul_a     = coef.b2;
                mul_b     = b_x;
                step_next = ST_STORE_W1;
            end
            ST_STORE_W1: begin
                // old w2 still in place here
                w1_next   = sat_state(acc_reg + w2_ext);
                acc_next  = prod_term;
                mul_a     = coef.a2;
                mul_b     = b_hi;
                step_next = ST_SUB_A2_HI;
            end
            ST_SUB_A2_HI: begin
                acc_next  = acc_reg - hi_term;
                mul_a     = coef.a2;
                mul_b     = b_lo;
                step_next = ST_SUB_A2_LO;
            end
            ST_SUB_A2_LO: begin
                acc_next  = acc_reg - lo_term;
                step_next = ST_STORE_W2;
            end
            ST_STORE_W2: begin
                w2_next   = sat_state(acc_reg);
                done      = 1'b1;
                step_next = ST_IDLE;
            end
            default: begin
                step_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mul_reg  <= mul_next;
        acc_reg  <= acc_next;
        bass_reg <= bass_next;
        if (!aresetn) begin
            step_reg <= ST_IDLE;
            w1_reg   <= '0;
            w2_reg   <= '0;
        end else begin
            step_reg <= step_next;
            w1_reg   <= w1_next;
            w2_reg   <= w2_next;
        end
    end

    assign bass = bass_reg;

endmodule

`default_nettype wire

// ----- design/sbmc_mix.sv -----
// ----------------------------------------------------------------------------
// Bass mix
// Merges the two lanes: each channel loses its own bass and gains the mono
// bass, then is scaled back to sample units and clamped. Bypass copies input.
// ----------------------------------------------------------------------------
`default_nettype none

module sbmc_mix (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire sbmc_pkg::mix_req_t                      req,
    input  wire logic signed [sbmc_pkg::SAMPLE_BITS-1:0] x_left,
    input  wire logic signed [sbmc_pkg::SAMPLE_BITS-1:0] x_right,
    input  wire logic signed [sbmc_pkg::STATE_BITS-1:0]  bass_left,
    input  wire logic signed [sbmc_pkg::STATE_BITS-1:0]  bass_right,
    output sbmc_pkg::mix_out_t                           result
);

    localparam int SB = sbmc_pkg::SAMPLE_BITS;
    localparam int WB = sbmc_pkg::STATE_BITS;
    localparam int TB = sbmc_pkg::ACC_BITS;
    localparam int SH = sbmc_pkg::COEF_FRAC_BITS + 1;
    localparam int QB = TB - SH;

    function automatic logic signed [SB-1:0] to_sample(input logic signed [TB-1:0] t);
        logic signed [TB-1:0] adj;
        logic signed [QB-1:0] q;
        logic [QB-SB:0]       top;
        // bias negatives so the shift truncates toward zero
        adj = t + (t[TB-1] ? {{(TB-SH){1'b0}}, {SH{1'b1}}} : {TB{1'b0}});
        q   = adj[TB-1:SH];
        top = q[QB-1:SB-1];
        if ((&top) || !(|top)) begin
            to_sample = q[SB-1:0];
        end else begin
            to_sample = {q[QB-1], {(SB-1){~q[QB-1]}}};
        end
    endfunction

    logic                  done_reg;
    logic signed [SB-1:0]  left_reg, left_next;
    logic signed [SB-1:0]  right_reg, right_next;
    logic signed [TB-1:0]  diff, t_left, t_right;

    assign diff = {{(TB-WB){bass_right[WB-1]}}, bass_right}
                - {{(TB-WB){bass_left[WB-1]}}, bass_left};
    assign t_left  = {{(TB-SB-SH){x_left[SB-1]}}, x_left, {SH{1'b0}}} + diff;
    assign t_right = {{(TB-SB-SH){x_right[SB-1]}}, x_right, {SH{1'b0}}} - diff;

    always_comb begin
        if (req.pass) begin
            left_next  = x_left;
            right_next = x_right;
        end else begin
            left_next  = to_sample(t_left);
            right_next = to_sample(t_right);
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= req.start;
        end
    end

    assign result.done      = done_reg;
    assign result.out_left  = left_reg;
    assign result.out_right = right_reg;

endmodule

`default_nettype wire

// ----- design/sbmc_checker.sv -----
// ----------------------------------------------------------------------------
// Crossover port checker
// Watches the top-level ports for output holding, reset and one-pair-at-a-
// time behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_bass_mono_crossover_top_defines.svh"

module sbmc_checker (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_tvalid,
    input wire logic                                 s_tready,
    input wire logic                                 m_tvalid,
    input wire logic                                 m_tready,
    input wire logic [2*sbmc_pkg::SAMPLE_BITS-1:0]   m_tdata
);

    // a stalled result beat stays put
    `SBMC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    `SBMC_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "result valid right after reset")

    // only one pair in flight
    `SBMC_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "input taken while a pair is in flight")

    // a result only shows up after the pair was worked on
    `SBMC_ASSERT(a_no_early_result, $rose(m_tvalid) |-> $past(!s_tready), "result appeared without processing")

endmodule

bind stereo_bass_mono_crossover_top sbmc_checker u_sbmc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- verif/tb_stereo_bass_mono_crossover_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bass-mono crossover testbench
// Drives stereo pairs and register writes into the crossover and checks every
// output pair against a cycle-free model of the biquad, the bass folding and
// the output saturation. A short directed plan comes first, then random
// phases, each with its own filter setting. Both bus sides idle in bursts.
// ----------------------------------------------------------------------------

module tb_stereo_bass_mono_crossover_top;
    import sbmc_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int ITEM_TARGET  = 1300;
    localparam int QUIET_ITEMS  = 150;
    localparam int TAIL_CYCLES  = 32;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int PLAN_ROWS    = 36;

    // indexes past the register map, writes there must be dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_7 = 3'd7;

    localparam longint I64_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN    = 64'sh8000_0000_0000_0000;
    localparam longint STATE_MAX  = (64'sd1 <<< (STATE_BITS - 1)) - 1;
    localparam longint STATE_MIN  = -STATE_MAX - 1;
    localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] right;
        logic signed [SAMPLE_BITS-1:0] left;
    } stereo_pair_t;

    typedef struct packed {
        longint bass;
        longint w1;
        longint w2;
    } lowpass_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_PAIR} row_kind_e;

    typedef struct packed {
        row_kind_e                 kind;
        logic [CFG_IDX_BITS-1:0]   idx;
        logic [COEF_BITS-1:0]      data;
        logic [SAMPLE_BITS-1:0]    left;
        logic [SAMPLE_BITS-1:0]    right;
        bit                        typed;
        logic [SAMPLE_BITS-1:0]    exp_left;
        logic [SAMPLE_BITS-1:0]    exp_right;
    } row_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [2*SAMPLE_BITS-1:0]      s_tdata   = '0;   // sample_right in the upper half, sample_left in the lower
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [2*SAMPLE_BITS-1:0]      m_tdata;          // out_right in the upper half, out_left in the lower
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
    logic [COEF_BITS-1:0]          cfg_data  = '0;

    stereo_bass_mono_crossover_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // model copy of registers and filter state
    bit                          mix_enable = 1'b0;
    logic signed [COEF_BITS-1:0] tap_b0 = '0, tap_b1 = '0, tap_b2 = '0;
    logic signed [COEF_BITS-1:0] tap_a1 = '0, tap_a2 = '0;
    longint                      dly1_l = 0, dly2_l = 0, dly1_r = 0, dly2_r = 0;

    stereo_pair_t mix_due [$];
    int           err_count   = 0;
    int unsigned  cycle_count = 0;
    bit           quiet       = 1'b0;
    bit           sender_gaps = 1'b1;
    bit           sink_stalls = 1'b1;
    int           drift       = 0;
    logic [SAMPLE_BITS-1:0] rail_words [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

    row_t plan [PLAN_ROWS] = '{
        // disabled after reset: straight copy
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h0000, 16'hFFFF, 1'b1, 16'h0000, 16'hFFFF},
        '{ROW_CFG,  CFG_SPARE_6, 32'hFFFF_FFFF,  16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  CFG_SPARE_7, 32'h0000_0001,  16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        // upper bits set, bit 0 clear: stays disabled
        '{ROW_CFG,  CFG_ENABLE,  32'hFFFF_FFFE,  16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h5555, 16'hAAAA, 1'b1, 16'h5555, 16'hAAAA},
        // enabled, all taps zero: bass is zero, so out equals in
        '{ROW_CFG,  CFG_ENABLE,  32'h0000_0001,  16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h1234, 16'hEDCB, 1'b1, 16'h1234, 16'hEDCB},
        // ~100 Hz low-pass at 48 kHz
        '{ROW_CFG,  CFG_COEF_B0, 32'h0000_B203,  16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  CFG_COEF_B1, 32'h0001_6406,  16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  CFG_COEF_B2, 32'h0000_B203,  16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  CFG_COEF_A1, -2127600000,    16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  CFG_COEF_A2, 1054040000,     16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h7FFF, 16'h7FFF, 1'b0, 16'h0,    16'h0},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h7FFF, 16'h7FFF, 1'b0, 16'h0,    16'h0},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h7FFF, 16'h8000, 1'b0, 16'h0,    16'h0},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h8000, 16'h7FFF, 1'b0, 16'h0,    16'h0},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h0000, 16'h0000, 1'b0, 16'h0,    16'h0},
        // extreme taps: runaway filter, state and output saturate
        '{ROW_CFG,  CFG_COEF_B0, 32'h7FFF_FFFF,  16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  CFG_COEF_B1, 32'h8000_0000,  16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  CFG_COEF_B2, 32'h7FFF_FFFF,  16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  CFG_COEF_A1, 32'h8000_0000,  16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_CFG,  CFG_COEF_A2, 32'h7FFF_FFFF,  16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h7FFF, 16'h8000, 1'b0, 16'h0,    16'h0},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h7FFF, 16'h8000, 1'b0, 16'h0,    16'h0},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h8000, 16'h7FFF, 1'b0, 16'h0,    16'h0},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h8000, 16'h8000, 1'b0, 16'h0,    16'h0},
        // disable: copy through, state frozen until re-enabled
        '{ROW_CFG,  CFG_ENABLE,  32'h0000_0000,  16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h0001, 16'hFFFF, 1'b1, 16'h0001, 16'hFFFF},
        '{ROW_CFG,  CFG_ENABLE,  32'h0000_0001,  16'h0,    16'h0,    1'b0, 16'h0,    16'h0},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h0000, 16'h0000, 1'b0, 16'h0,    16'h0},
        '{ROW_PAIR, CFG_ENABLE,  32'h0,          16'h4000, 16'hC000, 1'b0, 16'h0,    16'h0}
    };

    // ---------------- model arithmetic ----------------

    function automatic longint add_sat(longint a, longint b);
        logic signed [64:0] s;
        s = a + b;
        if (s > I64_MAX) return I64_MAX;
        if (s < I64_MIN) return I64_MIN;
        return s[63:0];
    endfunction

    function automatic longint sub_sat(longint a, longint b);
        logic signed [64:0] s;
        s = a - b;
        if (s > I64_MAX) return I64_MAX;
        if (s < I64_MIN) return I64_MIN;
        return s[63:0];
    endfunction

    function automatic longint clip_state(longint v);
        if (v > STATE_MAX) return STATE_MAX;
        if (v < STATE_MIN) return STATE_MIN;
        return v;
    endfunction

    // floor(x * c / 2^F), split into signed high and unsigned low 32-bit halves
    function automatic longint scale_by_coef(longint x, logic signed [COEF_BITS-1:0] c);
        longint cl, hi, lo, phi, plo, lim, hterm;
        cl  = longint'(c);
        hi  = x >>> 32;
        lo  = x & 64'h0000_0000_FFFF_FFFF;
        phi = cl * hi;
        plo = cl * lo;
        lim = I64_MAX >>> HI_SHIFT;
        if (phi > lim)
            hterm = I64_MAX;
        else if (phi < -lim - 1)
            hterm = I64_MIN;
        else
            hterm = phi <<< HI_SHIFT;
        return add_sat(hterm, plo >>> COEF_FRAC_BITS);
    endfunction

    // transposed direct form II, one sample
    function automatic lowpass_t lowpass(longint x, longint w1, longint w2);
        lowpass_t r;
        r.bass = clip_state(add_sat(longint'(tap_b0) * x, w1));
        r.w1   = clip_state(add_sat(sub_sat(longint'(tap_b1) * x,
                                            scale_by_coef(r.bass, tap_a1)), w2));
        r.w2   = clip_state(sub_sat(longint'(tap_b2) * x, scale_by_coef(r.bass, tap_a2)));
        return r;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rebuild(longint x, longint own,
                                                              longint other);
        longint t, q;
        t = add_sat(x <<< (COEF_FRAC_BITS + 1), sub_sat(other, own));
        q = t / (64'sd1 <<< (COEF_FRAC_BITS + 1));
        if (q > SAMPLE_MAX) q = SAMPLE_MAX;
        if (q < SAMPLE_MIN) q = SAMPLE_MIN;
        return q[SAMPLE_BITS-1:0];
    endfunction

    function automatic stereo_pair_t crossover_mix(stereo_pair_t x);
        lowpass_t     lo_l, lo_r;
        stereo_pair_t y;
        longint       xl, xr;
        if (!mix_enable) return x;
        xl = longint'(x.left);
        xr = longint'(x.right);
        lo_l = lowpass(xl, dly1_l, dly2_l);
        lo_r = lowpass(xr, dly1_r, dly2_r);
        dly1_l = lo_l.w1;
        dly2_l = lo_l.w2;
        dly1_r = lo_r.w1;
        dly2_r = lo_r.w2;
        y.left  = rebuild(xl, lo_l.bass, lo_r.bass);
        y.right = rebuild(xr, lo_r.bass, lo_l.bass);
        return y;
    endfunction

    // ---------------- bus drivers ----------------

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [COEF_BITS-1:0] val);
        if (s_tvalid) s_tvalid <= 1'b0;
        while (mix_due.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_ENABLE:  mix_enable = val[0];
            CFG_COEF_B0: tap_b0 = val;
            CFG_COEF_B1: tap_b1 = val;
            CFG_COEF_B2: tap_b2 = val;
            CFG_COEF_A1: tap_a1 = val;
            CFG_COEF_A2: tap_a2 = val;
            default: ;
        endcase
    endtask

    // valid stays high after the beat; the next call or the caller drops it
    task automatic send_pair(input stereo_pair_t x, input bit typed,
                             input stereo_pair_t typed_out);
        stereo_pair_t want;
        if (cfg_valid) cfg_valid <= 1'b0;
        if (!quiet && sender_gaps && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = crossover_mix(x);
        mix_due.push_back(typed ? typed_out : want);
    endtask

    function automatic stereo_pair_t random_pair();
        stereo_pair_t p;
        case ($urandom_range(0, 9))
            0, 1: p = $urandom;
            2: begin
                p.left  = rail_words[$urandom_range(0, 3)];
                p.right = rail_words[$urandom_range(0, 3)];
            end
            3: begin
                p.left  = $urandom;
                p.right = p.left;
            end
            4: begin
                p.left  = $urandom;
                p.right = -p.left;
            end
            default: begin
                // slow wander plus noise, i.e. mostly low-band content
                drift += int'($urandom_range(0, 4096)) - 2048;
                if (drift > 30000) drift = 30000;
                if (drift < -30000) drift = -30000;
                p.left  = drift + int'($urandom_range(0, 1023)) - 512;
                p.right = drift / 2 + int'($urandom_range(0, 2047)) - 1024;
            end
        endcase
        return p;
    endfunction

    // ---------------- result side ----------------

    initial begin : sink
        stereo_pair_t got, want;
        int           stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = m_tdata;
                if (mix_due.size() == 0) begin
                    $error("result beat %h with nothing outstanding", m_tdata);
                    err_count++;
                end else begin
                    want = mix_due.pop_front();
                    if (got.left !== want.left) begin
                        $error("out_left: expected %0d, got %0d", want.left, got.left);
                        err_count++;
                    end
                    if (got.right !== want.right) begin
                        $error("out_right: expected %0d, got %0d", want.right, got.right);
                        err_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet && sink_stalls && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 16);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run exceeded %0d cycles, %0d results outstanding",
                   CYCLE_LIMIT, mix_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    initial begin : stimulus
        int                   sent, phase_len, choice;
        logic [COEF_BITS-1:0] b0, b1, b2, a1, a2, en_word;
        sent = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].idx, plan[i].data);
            else
                send_pair({plan[i].right, plan[i].left}, plan[i].typed,
                          {plan[i].exp_right, plan[i].exp_left});
        end

        while (sent < ITEM_TARGET) begin
            phase_len   = $urandom_range(60, 140);
            choice      = $urandom_range(0, 9);
            sender_gaps = $urandom_range(0, 2) != 0;
            sink_stalls = $urandom_range(0, 2) != 0;
            if (choice <= 2) begin
                b0 = $urandom;
                b1 = $urandom;
                b2 = $urandom;
                a1 = $urandom;
                a2 = $urandom;
            end else if (choice <= 6) begin
                // ~100 Hz
                b0 = 32'd45571;
                b1 = 32'd91142;
                b2 = 32'd45571;
                a1 = -2127600000;
                a2 = 1054040000;
            end else begin
                // ~1 kHz
                b0 = 32'd4204800;
                b1 = 32'd8409600;
                b2 = 32'd4204800;
                a1 = -1949210000;
                a2 = 892287000;
            end
            en_word    = $urandom;
            en_word[0] = (choice != 0);
            write_reg(CFG_COEF_B0, b0);
            write_reg(CFG_COEF_B1, b1);
            write_reg(CFG_COEF_B2, b2);
            write_reg(CFG_COEF_A1, a1);
            write_reg(CFG_COEF_A2, a2);
            write_reg(CFG_ENABLE, en_word);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7, $urandom);
            repeat (phase_len) begin
                quiet = (sent >= ITEM_TARGET - QUIET_ITEMS);
                send_pair(random_pair(), 1'b0, '0);
                sent++;
            end
        end

        s_tvalid <= 1'b0;
        if (cfg_valid) cfg_valid <= 1'b0;
        while (mix_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
